/* hdl/fpq_pkg.sv */
// Shared types and constants for the four-level priority queue.
// No dependencies; the controller, datapath, top level and testbench import this package.
package fpq_pkg;

  localparam int NUM_LEVELS = 4;
  localparam int LVL_W      = 2;
  localparam int WORD_W     = 32;
  localparam int STATUS_W   = 2;

  localparam logic [LVL_W-1:0] LVL_TOP = 2'd0;
  localparam logic [LVL_W-1:0] LVL_LOW = 2'd3;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  localparam logic signed [WORD_W-1:0] EMPTY_VALUE = -32'sd1;
  localparam logic signed [WORD_W-1:0] ENQ_VALUE   = 32'sd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch the request payload
    logic exec;       // decide, update level state, issue RAM access
    logic read_load;  // load RAM read data into the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic deq_hit;    // latched request is a dequeue that finds an entry
    logic out_free;   // result register empty or draining this cycle
  } ctrl_sts_t;

endpackage

/* hdl/fpq_req_if.sv */
// Request channel of the priority queue: valid/ready plus enqueue/dequeue payload.
// No dependencies.
interface fpq_req_if;
  logic              valid;
  logic              ready;
  logic              kind;
  logic signed [31:0] value;
  logic [1:0]        priority_req;

  modport source (output valid, output kind, output value, output priority_req, input ready);
  modport sink   (input valid, input kind, input value, input priority_req, output ready);
endinterface

/* hdl/fpq_rsp_if.sv */
// Response channel of the priority queue: valid/ready plus result payload.
// No dependencies.
interface fpq_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_value;
  logic [1:0]         status;

  modport source (output valid, output out_value, output status, input ready);
  modport sink   (input valid, input out_value, input status, output ready);
endinterface

/* hdl/fpq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/fpq_ctrl.sv */
// Controller state machine of the priority queue: sequences capture, execute
// and RAM read wait. Depends on fpq_pkg.
module fpq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  fpq_pkg::ctrl_sts_t sts,
  output fpq_pkg::ctrl_cmd_t cmd
);
  import fpq_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.out_free) state_next = sts.deq_hit ? ST_RDWAIT : ST_IDLE;
      end
      ST_RDWAIT: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready     = 1'b0;
    cmd.capture   = 1'b0;
    cmd.exec      = 1'b0;
    cmd.read_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
      end
      ST_EXEC: begin
        cmd.exec = sts.out_free;
      end
      ST_RDWAIT: begin
        cmd.read_load = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

/* hdl/fpq_datapath.sv */
// Datapath of the priority queue: request register, per-level pointers and
// counts, shared entry RAM and result register. Depends on fpq_pkg, fpq_ram,
// fpq_rsp_if.
module fpq_datapath #(
  parameter int LEVEL_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_kind,
  input  logic signed [31:0] req_value,
  input  logic [1:0]         req_priority,
  input  fpq_pkg::ctrl_cmd_t cmd,
  output fpq_pkg::ctrl_sts_t sts,
  fpq_rsp_if.source          rsp
);
  import fpq_pkg::*;

  localparam int PTR_W  = $clog2(LEVEL_DEPTH);
  localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
  localparam int ADDR_W = LVL_W + PTR_W;
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(LEVEL_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(LEVEL_DEPTH);

  // Latched request
  logic                     kind;
  logic signed [WORD_W-1:0] value;
  logic [LVL_W-1:0]         lvl;

  // Level state
  logic [PTR_W-1:0] rptr  [NUM_LEVELS];
  logic [PTR_W-1:0] wptr  [NUM_LEVELS];
  logic [CNT_W-1:0] count [NUM_LEVELS];

  // Result register
  logic                     out_full;
  logic signed [WORD_W-1:0] out_value;
  logic [STATUS_W-1:0]      status;

  logic             any_valid;
  logic [LVL_W-1:0] best_lvl;
  logic             lvl_full;
  logic             enq_ok;
  logic             deq_ok;
  logic [WORD_W-1:0] ram_rdata;

  // Pick the best non-empty level, top first.
  always_comb begin
    any_valid = 1'b0;
    best_lvl  = LVL_TOP;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (count[i] != '0) begin
        any_valid = 1'b1;
        best_lvl  = LVL_W'(i);
      end
    end
  end

  assign lvl_full = (count[lvl] == CNT_FULL);
  assign enq_ok   = cmd.exec && (kind == KIND_ENQ) && !lvl_full;
  assign deq_ok   = cmd.exec && (kind == KIND_DEQ) && any_valid;

  assign sts.deq_hit  = (kind == KIND_DEQ) && any_valid;
  assign sts.out_free = !out_full || rsp.ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind  <= req_kind;
      value <= req_value;
      lvl   <= req_priority;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        rptr[i]  <= '0;
        wptr[i]  <= '0;
        count[i] <= '0;
      end
    end else begin
      if (enq_ok) begin
        wptr[lvl]  <= (wptr[lvl] == PTR_LAST) ? '0 : wptr[lvl] + 1'b1;
        count[lvl] <= count[lvl] + 1'b1;
      end
      if (deq_ok) begin
        rptr[best_lvl]  <= (rptr[best_lvl] == PTR_LAST) ? '0 : rptr[best_lvl] + 1'b1;
        count[best_lvl] <= count[best_lvl] - 1'b1;
      end
    end
  end

  fpq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (1 << ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (enq_ok),
    .waddr ({lvl, wptr[lvl]}),
    .wdata (value),
    .re    (deq_ok),
    .raddr ({best_lvl, rptr[best_lvl]}),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if ((cmd.exec && !sts.deq_hit) || cmd.read_load) begin
      out_full <= 1'b1;
    end else if (rsp.ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_load) begin
      out_value <= signed'(ram_rdata);
      status    <= STATUS_DONE;
    end else if (cmd.exec && !sts.deq_hit) begin
      if (kind == KIND_DEQ) begin
        out_value <= EMPTY_VALUE;
        status    <= STATUS_EMPTY;
      end else begin
        out_value <= ENQ_VALUE;
        status    <= lvl_full ? STATUS_FULL : STATUS_DONE;
      end
    end
  end

  assign rsp.valid     = out_full;
  assign rsp.out_value = out_value;
  assign rsp.status    = status;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count[0] <= CNT_FULL) && (count[1] <= CNT_FULL) &&
    (count[2] <= CNT_FULL) && (count[3] <= CNT_FULL))
    else $error("level count above depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec || cmd.read_load) |-> (!out_full || rsp.ready))
    else $error("result register overwritten while held");

  a_read_follows_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.read_load |-> $past(deq_ok))
    else $error("RAM data loaded without a dequeue read");

endmodule

/* hdl/four_level_priority_queue.sv */
// Four-level priority queue, first-in first-out within a level. Each request
// is an enqueue (value at priority 0 top .. 3 low) or a dequeue that returns
// the oldest value of the best non-empty level. Every request yields exactly
// one response: an enqueue answers 0 with status done, or status full when its
// level already holds LEVEL_DEPTH entries (the value is dropped); a dequeue
// answers the value with status done, or -1 with status empty. A request is
// taken in the idle state and executed in the execute state, where an enqueue
// or a failed dequeue loads its response into the result register; a successful
// dequeue then waits in a read-wait state for the registered read of the
// shared entry RAM. A new request is taken only back in the idle state. A
// response still waiting on the output does not block the next request from
// being taken; execution holds only if the result register is still occupied.
// Entry storage is not cleared at reset; only the per-level pointers, counts
// and result valid flag are, so the queue is usable right after reset.
// Depends on fpq_pkg, fpq_req_if, fpq_rsp_if, fpq_ctrl, fpq_datapath.
module four_level_priority_queue #(
  parameter int LEVEL_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  fpq_req_if.sink   req,
  fpq_rsp_if.source rsp
);
  import fpq_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Controller: owns the request handshake and sequences the datapath.
  fpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: level state, entry RAM and the result register that drives
  // the response transfer.
  fpq_datapath #(
    .LEVEL_DEPTH (LEVEL_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .req_kind     (req.kind),
    .req_value    (req.value),
    .req_priority (req.priority_req),
    .cmd          (cmd),
    .sts          (sts),
    .rsp          (rsp)
  );

endmodule

/* tb/four_level_priority_queue_tb.sv */
// Self-checking testbench for the four-level priority queue.
// Depends on fpq_pkg, fpq_req_if, fpq_rsp_if and four_level_priority_queue.
// Shadows the queue per level, drives bursty requests and a stalling receiver.
module four_level_priority_queue_tb;
  import fpq_pkg::*;

  localparam int LEVEL_DEPTH = 16;
  localparam int RANDOM_ITEMS = 924;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 150;
  localparam int HOLD_AFTER = 400;
  localparam int DRAIN_CYCLES = 8;

  // Names for the two middle levels; top and low come from the package.
  localparam logic [LVL_W-1:0] LVL_HIGH = 2'd1;
  localparam logic [LVL_W-1:0] LVL_NORMAL = 2'd2;

  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

  typedef struct {
    logic signed [WORD_W-1:0] out_value;
    logic [STATUS_W-1:0] status;
  } answer_t;

  typedef struct {
    logic [LVL_W-1:0] lvl;
    logic signed [WORD_W-1:0] value;
  } held_entry_t;

  // Shadow of the queue contents plus the answers still owed by the block.
  class queue_shadow;
    int depth;
    int level_fill[NUM_LEVELS];
    held_entry_t held[$];
    answer_t owed_answers[$];
    int n_enq, n_deq, n_full, n_empty, n_errors;

    function new(int d);
      depth = d;
      foreach (level_fill[l]) level_fill[l] = 0;
    endfunction

    function int owed();
      return owed_answers.size();
    endfunction

    // Apply one accepted request and queue the answer it must produce.
    function void note_request(logic kind, logic signed [WORD_W-1:0] value,
                               logic [LVL_W-1:0] lvl);
      answer_t a;
      held_entry_t e;
      int best;
      a.out_value = ENQ_VALUE;
      a.status = STATUS_DONE;
      if (kind == KIND_ENQ) begin
        n_enq++;
        if (level_fill[lvl] >= depth) begin
          a.status = STATUS_FULL;
          n_full++;
        end else begin
          e.lvl = lvl;
          e.value = value;
          held.push_back(e);
          level_fill[lvl]++;
        end
      end else begin
        n_deq++;
        best = -1;
        for (int l = LVL_TOP; l <= LVL_LOW; l++) begin
          if (best < 0 && level_fill[l] != 0) best = l;
        end
        if (best < 0) begin
          a.out_value = EMPTY_VALUE;
          a.status = STATUS_EMPTY;
          n_empty++;
        end else begin
          // Oldest entry of the best level is the first one of it in arrival order.
          for (int i = 0; i < held.size(); i++) begin
            if (held[i].lvl == best) begin
              a.out_value = held[i].value;
              held.delete(i);
              break;
            end
          end
          level_fill[best]--;
        end
      end
      owed_answers.push_back(a);
    endfunction

    function void check_answer(logic signed [WORD_W-1:0] out_value,
                               logic [STATUS_W-1:0] status);
      answer_t a;
      if (owed_answers.size() == 0) begin
        $display("%0t: unexpected answer value %0d status %0d", $time, out_value, status);
        n_errors++;
        return;
      end
      a = owed_answers.pop_front();
      if (out_value !== a.out_value) begin
        $display("%0t: out_value mismatch, expected %0d actual %0d",
                 $time, a.out_value, out_value);
        n_errors++;
      end
      if (status !== a.status) begin
        $display("%0t: status mismatch, expected %0d actual %0d", $time, a.status, status);
        n_errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  fpq_req_if req_if();
  fpq_rsp_if rsp_if();

  queue_shadow shadow = new(LEVEL_DEPTH);

  int cycles = 0;
  int answers_seen = 0;
  int burst_left = 0;

  four_level_priority_queue #(
    .LEVEL_DEPTH(LEVEL_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop so a hung handshake cannot run forever.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Check every response transfer; values are sampled before the edge updates them.
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      shadow.check_answer(rsp_if.out_value, rsp_if.status);
      answers_seen++;
    end
  end

  // Receiver: switch between stall patterns, and once hold off for a long
  // stretch so the result register backs up and the request side stalls.
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    bit held_once;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    held_once = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && !held_once && answers_seen >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        held_once = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          0: rsp_if.ready <= 1'b1;
          1: rsp_if.ready <= 1'($urandom_range(0, 1));
          2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_if.ready <= (mode_left % 6) < 3;
        endcase
      end
    end
  end

  // Offer one request and hold it until the transfer; leaves valid high so
  // the next request can follow back to back.
  task automatic send_request(input logic kind, input logic signed [WORD_W-1:0] value,
                              input logic [LVL_W-1:0] lvl);
    req_if.valid <= 1'b1;
    req_if.kind <= kind;
    req_if.value <= value;
    req_if.priority_req <= lvl;
    do @(posedge clk); while (!req_if.ready);
    shadow.note_request(kind, value, lvl);
  endtask

  // Sender pacing: bursts of random length separated by random gaps.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  function automatic logic signed [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int enq_pct;
    int focus;
    logic kind;
    logic [LVL_W-1:0] lvl;

    rst <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.kind <= KIND_ENQ;
    req_if.value <= '0;
    req_if.priority_req <= LVL_TOP;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: dequeue from an empty queue, with junk in the ignored fields.
    send_request(KIND_DEQ, 32'sh5a5a_5a5a, LVL_LOW);
    // Word extremes, one per level, entered worst level first.
    send_request(KIND_ENQ, WORD_MAX, LVL_LOW);
    send_request(KIND_ENQ, WORD_MIN, LVL_NORMAL);
    send_request(KIND_ENQ, -32'sd1, LVL_HIGH);
    send_request(KIND_ENQ, 32'sd0, LVL_TOP);
    // Drain: must come back in level order, top first.
    repeat (4) send_request(KIND_DEQ, pick_value(), LVL_W'($urandom_range(0, 3)));
    // Fill one level to its depth, then push one more into the full level.
    repeat (LEVEL_DEPTH + 1) send_request(KIND_ENQ, pick_value(), LVL_HIGH);

    // Random phases: each has its own enqueue rate and an optional favored
    // level, so levels fill, overflow, wrap their pointers and run dry.
    enq_pct = 50;
    focus = NUM_LEVELS;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: enq_pct = 15;
          1: enq_pct = 50;
          2: enq_pct = 85;
          default: enq_pct = 95;
        endcase
        focus = $urandom_range(0, NUM_LEVELS);
      end
      kind = ($urandom_range(0, 99) < enq_pct) ? KIND_ENQ : KIND_DEQ;
      if (focus == NUM_LEVELS || $urandom_range(0, 3) == 0)
        lvl = LVL_W'($urandom_range(0, 3));
      else
        lvl = focus[LVL_W-1:0];
      pace();
      send_request(kind, pick_value(), lvl);
    end
    req_if.valid <= 1'b0;

    // Wait for every owed answer, then keep watching for strays before the summary.
    while (shadow.owed() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d enqueues (%0d refused on a full level) and %0d dequeues",
             shadow.n_enq, shadow.n_full, shadow.n_deq);
    $display("(%0d on an empty queue), %0d answers checked, %0d mismatches",
             shadow.n_empty, answers_seen, shadow.n_errors);
    if (shadow.n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
